### hdl/key_sequence_detector_assert.svh
// Assertion macros shared by the key sequence detector RTL.
`ifndef KEY_SEQUENCE_DETECTOR_ASSERT_SVH
`define KEY_SEQUENCE_DETECTOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define KSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key sequence detector check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define KSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key sequence detector check failed");
`else
`define KSD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/ksd_pkg.sv
// Shared types and constants of the key sequence detector.
package ksd_pkg;

   // Field widths fixed by the word formats.
   localparam int MODE_W     = 2;
   localparam int KEY_W      = 32;
   localparam int TIME_W     = 32;
   localparam int SLOT_W     = 4;
   localparam int POS_W      = 5;
   localparam int LEN_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   // Smallest sequence length that the detector honors.
   localparam logic [LEN_W-1:0] LEN_MIN = 5'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_PRESS = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_COMBO_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_KEY_DELAY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_ON_WRONG = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_ON_MATCH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DELETE_ON_MATCH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DETECTOR_ENABLE = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [LEN_W-1:0]  COMBO_LENGTH_RST  = 5'd3;
   localparam logic [TIME_W-1:0] MAX_KEY_DELAY_RST = 32'd0;

endpackage

### hdl/ksd_ram.sv
// Generic single-port-write, registered-read RAM.
module ksd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a collision with a write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/key_sequence_detector.sv
// Key sequence detector: matches timestamped key presses against a stored sequence.
// Each word passes through the input register and then the output register before its result word is presented.
// Throughput: one word per cycle while rsp_tready is high; the input register, the table
// RAM read and the output register all advance together, so back-to-back words flow without gaps.
// Reset clears progress and loads the register defaults; the sequence table is
// undefined until its entries are written.
`include "key_sequence_detector_assert.svh"

module key_sequence_detector #(
   parameter int MAX_KEYS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // key_code[31:0], event_time[63:32], entry_position[67:64]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // combo_matched[0], delete_request[1], progress[6:2],
                                    // key_accepted[7]
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_KEYS);
   // combo_length is five bits wide, so the usable length also never exceeds 31.
   localparam int LEN_CAP_INT = (MAX_KEYS > 31) ? 31 : MAX_KEYS;
   localparam logic [ksd_pkg::LEN_W-1:0] LEN_CAP = ksd_pkg::LEN_W'(LEN_CAP_INT);

   // Configuration registers.
   logic [ksd_pkg::LEN_W-1:0]  combo_length_ff;
   logic [ksd_pkg::TIME_W-1:0] max_key_delay_ff;
   logic                       reset_on_wrong_ff;
   logic                       reset_on_match_ff;
   logic                       delete_on_match_ff;
   logic                       enabled_ff;

   // Detector state.
   logic [ksd_pkg::POS_W-1:0]  position_ff, position_in;
   logic [ksd_pkg::TIME_W-1:0] last_time_ff, last_time_in;
   logic                       done_ff, done_in;

   // Input register.
   logic                       in_valid_ff;
   ksd_pkg::mode_type          in_mode_ff;
   logic [ksd_pkg::KEY_W-1:0]  in_key_ff;
   logic [ksd_pkg::TIME_W-1:0] in_time_ff;
   logic [ksd_pkg::SLOT_W-1:0] in_slot_ff;

   // Output register.
   logic                       out_valid_ff;
   logic                       out_matched_ff, out_matched_in;
   logic                       out_delete_ff, out_delete_in;
   logic [ksd_pkg::POS_W-1:0]  out_progress_ff;
   logic                       out_accepted_ff, out_accepted_in;

   // Table access.
   logic                       tbl_wr_en;
   logic [IDX_W-1:0]           tbl_wr_addr;
   logic [IDX_W-1:0]           tbl_rd_addr;
   logic [ksd_pkg::KEY_W-1:0]  tbl_rd_data;
   logic                       bypass_ff;
   logic [ksd_pkg::KEY_W-1:0]  bypass_key_ff;
   logic [ksd_pkg::KEY_W-1:0]  expected_key;

   logic                       move;
   logic                       req_fire;
   logic [ksd_pkg::LEN_W-1:0]  eff_len;
   logic [ksd_pkg::TIME_W-1:0] time_limit;
   logic                       key_ok;
   logic [ksd_pkg::POS_W-1:0]  position_inc;

   // The word in the input register moves to the output register whenever the
   // output register is empty or is being drained in the same cycle.
   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // The sequence length in use is clamped to the supported range.
   always_comb begin
      if (combo_length_ff < ksd_pkg::LEN_MIN) begin
         eff_len = ksd_pkg::LEN_MIN;
      end else if (combo_length_ff > LEN_CAP) begin
         eff_len = LEN_CAP;
      end else begin
         eff_len = combo_length_ff;
      end
   end

   // The table is read every cycle at the position that the state will hold
   // next, so the expected key is ready when the following word is evaluated.
   // A write to that same entry in the same cycle is forwarded past the RAM.
   assign tbl_wr_en   = move && (in_mode_ff == ksd_pkg::MODE_WRITE) &&
                        (32'(in_slot_ff) < 32'(MAX_KEYS));
   assign tbl_wr_addr = IDX_W'(in_slot_ff);
   assign tbl_rd_addr = IDX_W'(position_in);
   assign expected_key = bypass_ff ? bypass_key_ff : tbl_rd_data;

   ksd_ram #(
      .WIDTH (ksd_pkg::KEY_W),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (in_key_ff),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // The deadline wraps at 32 bits, as the timestamps do.
   assign time_limit   = last_time_ff + max_key_delay_ff;
   assign position_inc = position_ff + 5'd1;
   assign key_ok = (position_ff < eff_len) && (in_key_ff == expected_key) &&
                   ((position_ff == '0) || (max_key_delay_ff == '0) ||
                    (in_time_ff <= time_limit));

   // Evaluation of the word held in the input register.
   always_comb begin
      position_in     = position_ff;
      last_time_in    = last_time_ff;
      done_in         = done_ff;
      out_matched_in  = 1'b0;
      out_delete_in   = 1'b0;
      out_accepted_in = 1'b0;
      if (move) begin
         case (in_mode_ff)
            ksd_pkg::MODE_CLEAR: begin
               position_in  = '0;
               last_time_in = '0;
               done_in      = 1'b0;
            end
            ksd_pkg::MODE_PRESS: begin
               if (enabled_ff && !done_ff) begin
                  if (key_ok) begin
                     out_accepted_in = 1'b1;
                     last_time_in    = in_time_ff;
                     position_in     = position_inc;
                     if (position_inc == eff_len) begin
                        out_matched_in = 1'b1;
                        if (reset_on_match_ff) begin
                           position_in  = '0;
                           last_time_in = '0;
                        end else begin
                           // Without a rewind the detector stays matched and
                           // ignores presses until a reset word arrives.
                           done_in       = 1'b1;
                           out_delete_in = delete_on_match_ff;
                        end
                     end
                  end else if (reset_on_wrong_ff) begin
                     position_in = '0;
                  end
               end
            end
            default: begin
               // Table writes are handled by the RAM port; unused codes do nothing.
            end
         endcase
      end
   end

   // Control state, configuration and the handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         position_ff        <= '0;
         last_time_ff       <= '0;
         done_ff            <= 1'b0;
         bypass_ff          <= 1'b0;
         combo_length_ff    <= ksd_pkg::COMBO_LENGTH_RST;
         max_key_delay_ff   <= ksd_pkg::MAX_KEY_DELAY_RST;
         reset_on_wrong_ff  <= 1'b1;
         reset_on_match_ff  <= 1'b1;
         delete_on_match_ff <= 1'b0;
         enabled_ff         <= 1'b1;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         position_ff  <= position_in;
         last_time_ff <= last_time_in;
         done_ff      <= done_in;
         bypass_ff    <= tbl_wr_en && (tbl_wr_addr == tbl_rd_addr);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ksd_pkg::REG_COMBO_LENGTH:    combo_length_ff    <= csr_data[ksd_pkg::LEN_W-1:0];
               ksd_pkg::REG_MAX_KEY_DELAY:   max_key_delay_ff   <= csr_data;
               ksd_pkg::REG_RESET_ON_WRONG:  reset_on_wrong_ff  <= csr_data[0];
               ksd_pkg::REG_RESET_ON_MATCH:  reset_on_match_ff  <= csr_data[0];
               ksd_pkg::REG_DELETE_ON_MATCH: delete_on_match_ff <= csr_data[0];
               ksd_pkg::REG_DETECTOR_ENABLE: enabled_ff         <= csr_data[0];
               default: begin
                  // Writes to unknown registers are dropped.
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff <= ksd_pkg::mode_type'(req_tuser);
         in_key_ff  <= req_tdata[31:0];
         in_time_ff <= req_tdata[63:32];
         in_slot_ff <= req_tdata[67:64];
      end
      if (move) begin
         out_matched_ff  <= out_matched_in;
         out_delete_ff   <= out_delete_in;
         out_progress_ff <= position_in;
         out_accepted_ff <= out_accepted_in;
      end
      bypass_key_ff <= in_key_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_accepted_ff, out_progress_ff, out_delete_ff, out_matched_ff};

   // A delete request only ever comes with a completed sequence.
   `KSD_ASSERT_IMPLY(a_delete_needs_match, clock, reset,
                     out_valid_ff && out_delete_ff, out_matched_ff)
   // While matched and waiting, the position sits at a full sequence length.
   `KSD_ASSERT_IMPLY(a_done_has_position, clock, reset,
                     done_ff, position_ff >= ksd_pkg::LEN_MIN)
   // Progress only changes when a word is evaluated.
   `KSD_ASSERT_NEXT(a_state_holds_when_idle, clock, reset,
                    !move, $stable(position_ff) && $stable(done_ff))
   // Forwarding is only armed by a table write in the cycle before.
   `KSD_ASSERT_IMPLY(a_bypass_after_write, clock, reset,
                     bypass_ff, $past(tbl_wr_en))

endmodule
